// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mrs_pkg.sv =====
// Types and constants of the multinomial row sampler.
package mrs_pkg;

   localparam int THR_W     = 54;
   localparam int DRAW_W    = 53;
   localparam int CAT_W     = 4;
   localparam int CNT_W     = 31;
   localparam int ROW_W     = 32;
   localparam int CCOUNT_W  = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
   localparam logic [63:0] ROW_MUL      = 64'hD1B54A32D192ED03;
   localparam logic [63:0] SEED_RESET   = 64'd7;

   // Register indexes; each register sits at byte address 8 * index.
   localparam logic [1:0] REG_RNG_SEED       = 2'd0;
   localparam logic [1:0] REG_TRIALS_PER_ROW = 2'd1;
   localparam logic [1:0] REG_CATEGORY_COUNT = 2'd2;

   // Input actions.
   localparam logic ACT_WRITE_THRESHOLD = 1'b0;
   localparam logic ACT_SAMPLE_ROW      = 1'b1;

   typedef struct packed {
      logic               action;
      logic [CAT_W-1:0]   entry_index;
      logic [THR_W-1:0]   threshold;
      logic [ROW_W-1:0]   row_index;
   } mrs_req_type;

   typedef struct packed {
      logic [CAT_W-1:0]   category;
      logic [CNT_W-1:0]   hit_count;
      logic               last_category;
   } mrs_rsp_type;

endpackage

// ===== rtl/core/multinomial_row_sampler_top.sv =====
// Multinomial row sampler: splitmix64 draws inverted through a threshold table.
//
//   channel   direction  handshake                      payload
//   request   in         start high while busy low      req_data (mrs_req_type)
//   response  out        rsp_strobe, one cycle, no hold rsp_data (mrs_rsp_type)
//   csr       in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A row is seeded, clears the histogram, then runs each trial as an advance,
// two mix steps, up to ceil(log2 d) binary search steps for d categories and
// a histogram update, and finally emits one result per category.
// The seeding and mix steps share one 32x32 multiplier, which builds each
// 64-bit product from three partial products.
// Reset is synchronous; the histogram needs no pass since every row clears it.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module multinomial_row_sampler_top #(
   parameter int MAX_CATEGORIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  mrs_pkg::mrs_req_type              req_data,
   output logic                              rsp_strobe,
   output mrs_pkg::mrs_rsp_type              rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mrs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mrs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mrs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import mrs_pkg::*;

   localparam int IDX_W = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
   localparam int CMP_W = ($clog2(MAX_CATEGORIES + 1) > CCOUNT_W) ?
                          $clog2(MAX_CATEGORIES + 1) : CCOUNT_W;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_SEED_MUL   = 12'b0000_0000_0010,
      ST_CLEAR      = 12'b0000_0000_0100,
      ST_ADVANCE    = 12'b0000_0000_1000,
      ST_MIX1       = 12'b0000_0001_0000,
      ST_MIX2       = 12'b0000_0010_0000,
      ST_SEARCH_RD  = 12'b0000_0100_0000,
      ST_SEARCH_CMP = 12'b0000_1000_0000,
      ST_HIST_RD    = 12'b0001_0000_0000,
      ST_HIST_WR    = 12'b0010_0000_0000,
      ST_EMIT_RD    = 12'b0100_0000_0000,
      ST_EMIT_OUT   = 12'b1000_0000_0000
   } state_type;

   // Configuration registers.
   logic [63:0]          seed_ff;
   logic [CNT_W-1:0]     trials_ff;
   logic [CCOUNT_W-1:0]  ccount_ff;

   // Control and datapath registers.
   state_type            state_ff, state_in;
   logic [1:0]           mstep_ff, mstep_in;
   logic [63:0]          mul_a_ff, mul_a_in;
   logic [63:0]          prod_ff, prod_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          gen_ff, gen_in;
   logic [DRAW_W-1:0]    draw_ff, draw_in;
   logic [IDX_W-1:0]     last_ff, last_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     trial_ff, trial_in;

   // Memories and their registered read data.
   logic [THR_W-1:0]     thr_mem [MAX_CATEGORIES];
   logic [CNT_W-1:0]     hist_mem [MAX_CATEGORIES];
   logic [THR_W-1:0]     thr_rd_ff;
   logic [CNT_W-1:0]     hist_rd_ff;

   logic                 accept;
   logic                 csr_write;
   logic                 thr_we;
   logic [IDX_W-1:0]     srch_mid;
   logic [IDX_W-1:0]     hist_raddr;
   logic                 hist_we;
   logic [IDX_W-1:0]     hist_waddr;
   logic [CNT_W-1:0]     hist_wdata;
   logic [31:0]          pa, pb;
   logic [63:0]          mul_b;
   logic [63:0]          mul_res;
   logic [63:0]          gen_next;
   logic [63:0]          mix_out;
   logic [CMP_W-1:0]     cc_ext;
   logic [IDX_W-1:0]     last_calc;
   logic                 thr_ge;
   logic [IDX_W-1:0]     nlo, nhi;
   logic [CNT_W-1:0]     trial_next;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= SEED_RESET;
         trials_ff <= '0;
         ccount_ff <= CCOUNT_W'(1);
      end else if (csr_write) begin
         case (paddr[4:3])
            REG_RNG_SEED:       seed_ff   <= pwdata;
            REG_TRIALS_PER_ROW: trials_ff <= pwdata[CNT_W-1:0];
            REG_CATEGORY_COUNT: ccount_ff <= pwdata[CCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:3])
         REG_RNG_SEED:       prdata = seed_ff;
         REG_TRIALS_PER_ROW: prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, trials_ff};
         REG_CATEGORY_COUNT: prdata = {{(CSR_DATA_W-CCOUNT_W){1'b0}}, ccount_ff};
         default:            prdata = '0;
      endcase
   end

   // Threshold table.
   assign thr_we = accept && (req_data.action == ACT_WRITE_THRESHOLD) &&
                   (32'(req_data.entry_index) < 32'(MAX_CATEGORIES));
   assign srch_mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_ff @(posedge clock) begin
      if (thr_we) begin
         thr_mem[IDX_W'(req_data.entry_index)] <= req_data.threshold;
      end
      thr_rd_ff <= thr_mem[srch_mid];
   end

   // Histogram; each row clears it before its first trial.
   assign hist_raddr = (state_ff == ST_EMIT_RD) ? idx_ff : lo_ff;
   assign hist_we    = (state_ff == ST_CLEAR) || (state_ff == ST_HIST_WR);
   assign hist_waddr = (state_ff == ST_CLEAR) ? idx_ff : lo_ff;
   assign hist_wdata = (state_ff == ST_CLEAR) ? '0 : hist_rd_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   // Shared multiplier: the low 64 bits of a 64x64 product come from the
   // low-low product plus both cross products shifted up by 32 bits.
   always_comb begin
      case (state_ff)
         ST_SEED_MUL: mul_b = ROW_MUL;
         ST_MIX1:     mul_b = MIX_MUL_A;
         default:     mul_b = MIX_MUL_B;
      endcase
      case (mstep_ff)
         2'd1:    begin pa = mul_a_ff[63:32]; pb = mul_b[31:0];  end
         2'd2:    begin pa = mul_a_ff[31:0];  pb = mul_b[63:32]; end
         default: begin pa = mul_a_ff[31:0];  pb = mul_b[31:0];  end
      endcase
   end

   assign prod_in = pa * pb;
   assign mul_res = acc_ff + {prod_ff[31:0], 32'b0};
   assign gen_next = gen_ff + GOLDEN_GAMMA;
   assign mix_out  = mul_res ^ (mul_res >> 31);

   // Category count clamped to 1..MAX_CATEGORIES, kept as the last index.
   assign cc_ext = CMP_W'(ccount_ff);
   always_comb begin
      if (ccount_ff == '0) begin
         last_calc = '0;
      end else if (cc_ext > CMP_W'(MAX_CATEGORIES)) begin
         last_calc = IDX_W'(MAX_CATEGORIES - 1);
      end else begin
         last_calc = IDX_W'(cc_ext - 1'b1);
      end
   end

   assign thr_ge     = (thr_rd_ff >= {1'b0, draw_ff});
   assign nlo        = thr_ge ? lo_ff : srch_mid + 1'b1;
   assign nhi        = thr_ge ? srch_mid : hi_ff;
   assign trial_next = trial_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      mstep_in = mstep_ff;
      mul_a_in = mul_a_ff;
      acc_in   = acc_ff;
      gen_in   = gen_ff;
      draw_in  = draw_ff;
      last_in  = last_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      trial_in = trial_ff;

      if ((state_ff == ST_SEED_MUL) || (state_ff == ST_MIX1) || (state_ff == ST_MIX2)) begin
         mstep_in = mstep_ff + 1'b1;
         if (mstep_ff == 2'd1) begin
            acc_in = prod_ff;
         end else if (mstep_ff == 2'd2) begin
            acc_in = mul_res;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.action == ACT_SAMPLE_ROW)) begin
               mul_a_in = 64'(req_data.row_index) + 64'd1;
               last_in  = last_calc;
               mstep_in = '0;
               state_in = ST_SEED_MUL;
            end
         end
         ST_SEED_MUL: begin
            if (mstep_ff == 2'd3) begin
               gen_in   = seed_ff ^ mul_res;
               idx_in   = '0;
               trial_in = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == last_ff) begin
               if (trials_ff == '0) begin
                  idx_in   = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_ADVANCE;
               end
            end
         end
         ST_ADVANCE: begin
            gen_in   = gen_next;
            mul_a_in = gen_next ^ (gen_next >> 30);
            mstep_in = '0;
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            if (mstep_ff == 2'd3) begin
               mul_a_in = mul_res ^ (mul_res >> 27);
               state_in = ST_MIX2;
            end
         end
         ST_MIX2: begin
            if (mstep_ff == 2'd3) begin
               draw_in  = mix_out[63:11] | DRAW_W'(1);
               lo_in    = '0;
               hi_in    = last_ff;
               state_in = (last_ff == '0) ? ST_HIST_RD : ST_SEARCH_RD;
            end
         end
         ST_SEARCH_RD: begin
            state_in = ST_SEARCH_CMP;
         end
         ST_SEARCH_CMP: begin
            lo_in    = nlo;
            hi_in    = nhi;
            state_in = (nlo == nhi) ? ST_HIST_RD : ST_SEARCH_RD;
         end
         ST_HIST_RD: begin
            state_in = ST_HIST_WR;
         end
         ST_HIST_WR: begin
            trial_in = trial_next;
            if (trial_next == trials_ff) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == last_ff) ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mstep_ff <= '0;
         gen_ff   <= '0;
         trial_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         gen_ff   <= gen_in;
         trial_ff <= trial_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      draw_ff  <= draw_in;
      last_ff  <= last_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

   // Results come straight from the histogram read register.
   assign rsp_strobe             = (state_ff == ST_EMIT_OUT);
   assign rsp_data.category      = CAT_W'(idx_ff);
   assign rsp_data.hit_count     = hist_rd_ff;
   assign rsp_data.last_category = (idx_ff == last_ff);

   `ASSERT_IMP(a_strobe_busy, rsp_strobe, busy, "result strobe while idle")
   `ASSERT_NXT(a_last_idle, rsp_strobe && rsp_data.last_category, !busy,
               "block still busy after the last result of a row")
   `ASSERT_IMP(a_search_open, state_ff == ST_SEARCH_CMP, lo_ff < hi_ff,
               "search step taken on an empty interval")
   `ASSERT_IMP(a_cat_range, state_ff == ST_HIST_RD, lo_ff <= last_ff,
               "selected category beyond the categories in use")
   `ASSERT_IMP(a_trial_bound, state_ff == ST_HIST_WR, trial_ff < trials_ff,
               "more trials counted than configured")

endmodule
